// File: hw/rtl/modbus_rtu_frame_crc_engine_macros.svh
`ifndef MODBUS_RTU_FRAME_CRC_ENGINE_MACROS_SVH
`define MODBUS_RTU_FRAME_CRC_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mrc_pkg.sv
package mrc_pkg;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic REG_WORD_COUNT      = 1'b0;
  localparam logic REG_EXPECTED_LENGTH = 1'b1;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic        end_of_run;
    logic [7:0]  frame_len;
    logic        length_ok;
    logic        crc_ok;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [7:0]  byte_out;
    logic [1:0]  kind;
  } res_t;

  typedef struct packed {
    logic [1:0]       count;
    res_t [2:0]       ent;
  } grp_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] a;
    a = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
    end
    return a;
  endfunction

endpackage

// File: hw/rtl/mrc_frame.sv
module mrc_frame (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          func,
  input  logic [7:0]    byte_value,
  input  logic          last,
  input  logic [6:0]    word_count,
  input  logic [7:0]    expected_length,
  output mrc_pkg::grp_t grp
);
  import mrc_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  d0_r, d0_nxt;
  logic [7:0]  d1_r, d1_nxt;
  logic [7:0]  high_r, high_nxt;

  logic [7:0]  pos_inc;
  logic [15:0] crc_tx;
  logic [15:0] crc_rx;
  logic [7:0]  off;
  logic [6:0]  j;
  logic        word_zone;
  logic        word_fire;
  res_t        word_res;
  res_t        stat_res;

  always_comb begin
    pos_inc   = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 8'd1;
    crc_tx    = crc_byte(crc_r, byte_value);
    crc_rx    = (count_r >= 8'd2) ? crc_byte(crc_r, d0_r) : crc_r;
    off       = count_r - 8'd3;
    j         = off[7:1];
    word_zone = (count_r >= 8'd3) && (count_r != COUNT_MAX) && (j < word_count);
    word_fire = word_zone && off[0];

    word_res            = '0;
    word_res.kind       = KIND_WORD;
    word_res.word_value = {high_r, byte_value};
    word_res.word_index = j;
    word_res.end_of_run = !last;

    stat_res            = '0;
    stat_res.kind       = KIND_STATUS;
    stat_res.crc_ok     = (pos_inc >= 8'd3) && ({byte_value, d1_r} == crc_rx);
    stat_res.length_ok  = (pos_inc == expected_length);
    stat_res.frame_len  = pos_inc;
    stat_res.end_of_run = 1'b1;

    grp       = '0;
    crc_nxt   = crc_r;
    count_nxt = pos_inc;
    d0_nxt    = d0_r;
    d1_nxt    = d1_r;
    high_nxt  = high_r;

    if (!func) begin
      crc_nxt                = crc_tx;
      grp.ent[0].kind        = KIND_TX;
      grp.ent[0].byte_out    = byte_value;
      grp.ent[0].end_of_run  = !last;
      grp.ent[1].kind        = KIND_TX;
      grp.ent[1].byte_out    = crc_tx[7:0];
      grp.ent[2].kind        = KIND_TX;
      grp.ent[2].byte_out    = crc_tx[15:8];
      grp.ent[2].end_of_run  = 1'b1;
      grp.count              = last ? 2'd3 : 2'd1;
    end else begin
      crc_nxt = crc_rx;
      d0_nxt  = d1_r;
      d1_nxt  = byte_value;
      if (word_zone && !off[0]) begin
        high_nxt = byte_value;
      end
      if (word_fire) begin
        grp.ent[0] = word_res;
        grp.ent[1] = stat_res;
        grp.count  = last ? 2'd2 : 2'd1;
      end else begin
        grp.ent[0] = stat_res;
        grp.count  = last ? 2'd1 : 2'd0;
      end
    end

    if (last) begin
      crc_nxt   = CRC_PRESET;
      count_nxt = '0;
      d0_nxt    = '0;
      d1_nxt    = '0;
      high_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_PRESET;
      count_r <= '0;
      d0_r    <= '0;
      d1_r    <= '0;
      high_r  <= '0;
    end else if (accept) begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      d0_r    <= d0_nxt;
      d1_r    <= d1_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

// File: hw/rtl/mrc_out_stage.sv
module mrc_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  mrc_pkg::grp_t grp,
  output logic          can_load,
  output logic          res_valid,
  input  logic          res_ready,
  output mrc_pkg::res_t res
);
  import mrc_pkg::*;

  res_t [2:0] ent_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r, idx_nxt;

  always_comb begin
    res_valid = (idx_r != cnt_r);
    can_load  = !res_valid || (res_ready && ((idx_r + 2'd1) == cnt_r));
    idx_nxt   = (res_valid && res_ready) ? idx_r + 2'd1 : idx_r;
    case (idx_r)
      2'd1:    res = ent_r[1];
      2'd2:    res = ent_r[2];
      default: res = ent_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= grp.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= grp.count;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// File: hw/rtl/modbus_rtu_frame_crc_engine.sv
// Modbus RTU frame engine with CRC-16/MODBUS (preset FFFF, reflected poly A001).
// Input stream: one frame byte per transfer; in_tuser picks transmit (0) or
// receive (1), in_tlast marks the final byte of a frame.
// Result stream: out_tuser gives the result kind (transmit byte, register
// word, frame status); out_tlast marks the final result caused by one byte.
// Transmit: each byte is echoed; the last byte also appends the CRC, low
// byte first (three results). Receive: register words and, on the last
// byte, one status result; a byte may cause no result at all.
// Latency: first result of a byte is valid the cycle after its transfer.
// Throughput: one byte per cycle while out_tready is high and each byte causes
// at most one result; a byte causing more results holds the input until the
// result group register has drained them, one result per cycle while out_tready is high.
// Config: cfg_we writes word_count (index 0) or expected_length (index 1);
// write only while idle.
// Reset: frame state clears, word_count = 1, expected_length = 9, no result.
// Stall: while out_tready is low the pending result holds and in_tready stays
// low; a new byte is taken only when no result is pending or in the cycle the
// last pending result of the previous byte transfers.
module modbus_rtu_frame_crc_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] byte_out, [23:8] word_value, [30:24] word_index,
                                  // [31] crc_ok, [32] length_ok, [40:33] frame_len, zero pad
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import mrc_pkg::*;

  `include "modbus_rtu_frame_crc_engine_macros.svh"

  logic [6:0] word_count_r;
  logic [7:0] expected_length_r;
  logic       accept;
  grp_t       grp;
  res_t       res;
  logic       grp_busy;
  logic       out_end_xfer;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r      <= 7'd1;
      expected_length_r <= 8'd9;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WORD_COUNT:      word_count_r      <= cfg_wdata[6:0];
        REG_EXPECTED_LENGTH: expected_length_r <= cfg_wdata;
        default:             word_count_r      <= word_count_r;
      endcase
    end
  end

  mrc_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .func            (in_tuser),
    .byte_value      (in_tdata),
    .last            (in_tlast),
    .word_count      (word_count_r),
    .expected_length (expected_length_r),
    .grp             (grp)
  );

  mrc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .grp       (grp),
    .can_load  (in_tready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {7'd0, res.frame_len, res.length_ok, res.crc_ok,
                      res.word_index, res.word_value, res.byte_out};
  assign out_tuser = res.kind;
  assign out_tlast = res.end_of_run;

  assign grp_busy     = (grp.count != 2'd0);
  assign out_end_xfer = out_tvalid && out_tready && out_tlast;

  `MRC_ASSERT_NEXT(a_load_valid, clk, rst_n, accept, out_tvalid == $past(grp_busy), "bad valid")
  `MRC_ASSERT_NOW(a_idle_ready, clk, rst_n, !out_tvalid, in_tready, "input stalled while idle")
  `MRC_ASSERT_NOW(a_run_end_ready, clk, rst_n, out_end_xfer, in_tready, "stalled at run end")

endmodule
